@@ rtl/saturating_signed_alu_defines.svh @@
// Assertion macros for the saturating signed ALU.
`ifndef SATURATING_SIGNED_ALU_DEFINES_SVH
`define SATURATING_SIGNED_ALU_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SSA_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define SSA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/ssa_pkg.sv @@
// Types and constants shared by the saturating signed ALU.
`timescale 1ns / 1ps
`default_nettype none
package ssa_pkg;
	localparam int WIDTH = 32;

	localparam logic [WIDTH-1:0] SMAX = {1'b0, {(WIDTH-1){1'b1}}};
	localparam logic [WIDTH-1:0] SMIN = {1'b1, {(WIDTH-1){1'b0}}};

	typedef enum logic [2:0] {
		OP_ADD = 3'd0,
		OP_SUB = 3'd1,
		OP_NEG = 3'd2,
		OP_MUL = 3'd3,
		OP_DIV = 3'd4,
		OP_MOD = 3'd5
	} op_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_RANGE   = 2'd1,
		ST_DIVZERO = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		K_FIX = 2'd0,
		K_MUL = 2'd1,
		K_DIV = 2'd2,
		K_MOD = 2'd3
	} kind_t;

	typedef struct packed {
		logic [2:0]              op;
		logic signed [WIDTH-1:0] a_operand;
		logic signed [WIDTH-1:0] b_operand;
	} req_t;

	typedef struct packed {
		logic signed [WIDTH-1:0] result_value;
		logic [1:0]              status;
	} rsp_t;

	typedef struct packed {
		kind_t              kind;
		logic               neg;
		logic               rem_neg;
		logic [WIDTH-1:0]   fix_val;
		status_t            fix_st;
		logic [WIDTH-1:0]   dvs;
		logic [WIDTH-1:0]   mcand;
		logic [2*WIDTH-1:0] rq;
		logic [2*WIDTH:0]   pr;
	} cell_t;
endpackage
`default_nettype wire

@@ rtl/saturating_signed_alu.sv @@
// Pipeline: entry stage, 32 divide/multiply cells and output register,
// one cell per operand bit.
// Throughput: one item per cycle; the whole chain holds while a result
// waits under stall.
// Reset: arst_n clears every valid bit; no other state.
`timescale 1ns / 1ps
`default_nettype none
`include "saturating_signed_alu_defines.svh"
module saturating_signed_alu (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_stall,
	input  wire ssa_pkg::req_t req,
	output logic               rsp_valid,
	input  wire logic          rsp_stall,
	output ssa_pkg::rsp_t      rsp
);
	import ssa_pkg::*;

	logic        en;
	logic        vld   [0:WIDTH];
	cell_t       chain [0:WIDTH];

	assign en        = !(rsp_valid && rsp_stall);
	assign req_stall = !en;

	ssa_prep u_prep (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.vld_i  (req_valid),
		.d      (req),
		.vld_q  (vld[0]),
		.cell_q (chain[0])
	);

	for (genvar i = 0; i < WIDTH; i++) begin : g_cell
		ssa_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.vld_i  (vld[i]),
			.d      (chain[i]),
			.vld_q  (vld[i+1]),
			.cell_q (chain[i+1])
		);
	end

	ssa_post u_post (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.vld_i  (vld[WIDTH]),
		.d      (chain[WIDTH]),
		.vld_q  (rsp_valid),
		.rsp_q  (rsp)
	);

	`SSA_ASSERT_NOW(a_stall_only_on_full, req_stall, rsp_valid && rsp_stall, "stall without blocked result")
	`SSA_ASSERT_NOW(a_divzero_zero, rsp_valid && rsp.status == ST_DIVZERO, rsp.result_value == '0, "divide by zero result not zero")
	`SSA_ASSERT_NOW(a_range_sat, rsp_valid && rsp.status == ST_RANGE, rsp.result_value == SMIN || rsp.result_value == SMAX, "range error without saturated value")
	`SSA_ASSERT_NEXT(a_hold_chain, rsp_valid && rsp_stall, $stable(vld[0]) && $stable(vld[WIDTH]), "chain moved under stall")
endmodule
`default_nettype wire

@@ rtl/ssa_prep.sv @@
// Entry stage: direct add/sub/negate results, special cases and magnitudes.
`timescale 1ns / 1ps
`default_nettype none
module ssa_prep (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         en,
	input  wire logic         vld_i,
	input  wire ssa_pkg::req_t d,
	output logic              vld_q,
	output ssa_pkg::cell_t    cell_q
);
	import ssa_pkg::*;

	logic [WIDTH-1:0] a, b, mag_a, mag_b;
	logic [WIDTH:0]   s;
	cell_t            c;

	assign a     = d.a_operand;
	assign b     = d.b_operand;
	assign mag_a = a[WIDTH-1] ? (~a + 1'b1) : a;
	assign mag_b = b[WIDTH-1] ? (~b + 1'b1) : b;

	always_comb begin
		c         = '0;
		c.kind    = K_FIX;
		c.fix_st  = ST_OK;
		c.neg     = a[WIDTH-1] ^ b[WIDTH-1];
		c.rem_neg = a[WIDTH-1];
		c.dvs     = mag_b;
		c.mcand   = mag_a;
		c.rq      = {{WIDTH{1'b0}}, mag_a};
		c.pr      = {{(WIDTH+1){1'b0}}, mag_b};
		s         = '0;
		unique case (d.op) inside
			OP_ADD, OP_SUB, OP_NEG: begin
				if (d.op == OP_ADD) begin
					s = {a[WIDTH-1], a} + {b[WIDTH-1], b};
				end else if (d.op == OP_SUB) begin
					s = {a[WIDTH-1], a} - {b[WIDTH-1], b};
				end else begin
					s = {(WIDTH+1){1'b0}} - {a[WIDTH-1], a};
				end
				if (s[WIDTH] != s[WIDTH-1]) begin
					c.fix_val = s[WIDTH] ? SMIN : SMAX;
					c.fix_st  = ST_RANGE;
				end else begin
					c.fix_val = s[WIDTH-1:0];
				end
			end
			OP_MUL: c.kind = K_MUL;
			OP_DIV, OP_MOD: begin
				if (b == '0) begin
					c.fix_st = ST_DIVZERO;
				end else if (b == '1 && a == SMIN) begin
					c.fix_val = SMIN;
					c.fix_st  = ST_RANGE;
				end else begin
					c.kind = (d.op == OP_DIV) ? K_DIV : K_MOD;
				end
			end
			default: c.kind = K_FIX;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cell_q <= c;
		end
	end
endmodule
`default_nettype wire

@@ rtl/ssa_cell.sv @@
// One cell of the chain: one restoring divide step and one shift-add multiply step.
`timescale 1ns / 1ps
`default_nettype none
module ssa_cell (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          en,
	input  wire logic          vld_i,
	input  wire ssa_pkg::cell_t d,
	output logic               vld_q,
	output ssa_pkg::cell_t     cell_q
);
	import ssa_pkg::*;

	logic [WIDTH-1:0] hi;
	logic [WIDTH:0]   t;
	logic [WIDTH:0]   acc;
	cell_t            c;

	assign hi  = d.rq[2*WIDTH-2:WIDTH-1];
	assign t   = {1'b0, hi} - {1'b0, d.dvs};
	assign acc = d.pr[0] ? (d.pr[2*WIDTH:WIDTH] + {1'b0, d.mcand}) : d.pr[2*WIDTH:WIDTH];

	always_comb begin
		c = d;
		if (t[WIDTH]) begin
			c.rq = {hi, d.rq[WIDTH-2:0], 1'b0};
		end else begin
			c.rq = {t[WIDTH-1:0], d.rq[WIDTH-2:0], 1'b1};
		end
		c.pr = {1'b0, acc, d.pr[WIDTH-1:1]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cell_q <= c;
		end
	end
endmodule
`default_nettype wire

@@ rtl/ssa_post.sv @@
// Exit stage: sign fix, multiply saturation and the output register.
`timescale 1ns / 1ps
`default_nettype none
module ssa_post (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          en,
	input  wire logic          vld_i,
	input  wire ssa_pkg::cell_t d,
	output logic               vld_q,
	output ssa_pkg::rsp_t      rsp_q
);
	import ssa_pkg::*;

	logic [2*WIDTH-1:0] p;
	logic [WIDTH-1:0]   lim, q, r;
	rsp_t               o;

	assign p   = d.pr[2*WIDTH-1:0];
	assign lim = d.neg ? SMIN : SMAX;
	assign q   = d.rq[WIDTH-1:0];
	assign r   = d.rq[2*WIDTH-1:WIDTH];

	always_comb begin
		o.result_value = d.fix_val;
		o.status       = d.fix_st;
		case (d.kind)
			K_MUL: begin
				if (p > {{WIDTH{1'b0}}, lim}) begin
					o.result_value = d.neg ? SMIN : SMAX;
					o.status       = ST_RANGE;
				end else begin
					o.result_value = d.neg ? (~p[WIDTH-1:0] + 1'b1) : p[WIDTH-1:0];
					o.status       = ST_OK;
				end
			end
			K_DIV: begin
				o.result_value = d.neg ? (~q + 1'b1) : q;
				o.status       = ST_OK;
			end
			K_MOD: begin
				o.result_value = d.rem_neg ? (~r + 1'b1) : r;
				o.status       = ST_OK;
			end
			default: o.status = d.fix_st;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rsp_q <= o;
		end
	end
endmodule
`default_nettype wire
